FILE: rtl/dtlpm_pkg.sv
`default_nettype none
package dtlpm_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_BAD_SYM   = 3'd2;
  localparam logic [2:0] ST_POOL_FULL = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;

  localparam logic [7:0] DIGIT_BASE = 8'd48;
  localparam int KEY_W   = 6;
  localparam int DIGIT_W = 4;
  localparam int STEP_W  = 7;
  localparam logic [KEY_W-1:0] LOOKUP_LIMIT = 6'd63;

  typedef struct packed {
    logic       clear_step;
    logic       load_item;
    logic       take_child;
    logic       alloc;
    logic       set_err;
    logic [2:0] err_code;
    logic       mark_best;
    logic       set_hasv;
    logic       write_val;
    logic       inc_step;
    logic       walk_step;
    logic       walk_dec;
    logic       goto_best;
    logic       clear_hasv;
    logic       cursor_root;
    logic       capture_val;
    logic       result;
  } dtlpm_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_insert;
    logic is_remove;
    logic key_err;
    logic good;
    logic len_full;
    logic len_limit;
    logic child_zero;
    logic free_empty;
    logic free_zero;
    logic hasv;
    logic best_zero;
    logic cursor_root;
    logic step_over;
    logic last;
    logic out_free;
  } dtlpm_sts_t;

endpackage
`default_nettype wire

FILE: rtl/dtlpm_ctrl.sv
`default_nettype none
module dtlpm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire dtlpm_pkg::dtlpm_sts_t sts,
  output dtlpm_pkg::dtlpm_cmd_t     cmd
);

  typedef enum logic [16:0] {
    S_CLEAR     = 17'b00000000000000001,
    S_IDLE      = 17'b00000000000000010,
    S_DIGIT     = 17'b00000000000000100,
    S_CHILD     = 17'b00000000000001000,
    S_HV_WAIT   = 17'b00000000000010000,
    S_HV_USE    = 17'b00000000000100000,
    S_LAST      = 17'b00000000001000000,
    S_INS_HV    = 17'b00000000010000000,
    S_INC       = 17'b00000000100000000,
    S_INC_WAIT  = 17'b00000001000000000,
    S_VAL_WAIT  = 17'b00000010000000000,
    S_VAL_USE   = 17'b00000100000000000,
    S_DEC       = 17'b00001000000000000,
    S_DEC_WAIT  = 17'b00010000000000000,
    S_FAIL      = 17'b00100000000000000,
    S_FAIL_WAIT = 17'b01000000000000000,
    S_RESP      = 17'b10000000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (sts.key_err) state_next = S_LAST;
        else if (sts.is_insert) begin
          if (!sts.good) begin
            cmd.set_err = 1'b1; cmd.err_code = dtlpm_pkg::ST_BAD_SYM; state_next = S_FAIL;
          end else if (sts.len_full) begin
            cmd.set_err = 1'b1; cmd.err_code = dtlpm_pkg::ST_TOO_LONG; state_next = S_FAIL;
          end else state_next = S_CHILD;
        end else if (!sts.good || sts.len_limit) begin
          cmd.set_err = 1'b1; cmd.err_code = dtlpm_pkg::ST_NOT_FOUND; state_next = S_LAST;
        end else state_next = S_CHILD;
      end
      S_CHILD: begin
        if (sts.is_insert) begin
          if (!sts.child_zero) begin
            cmd.take_child = 1'b1; state_next = S_LAST;
          end else if (sts.free_empty) begin
            cmd.set_err = 1'b1; cmd.err_code = dtlpm_pkg::ST_POOL_FULL; state_next = S_FAIL;
          end else begin
            cmd.alloc = 1'b1;
            if (sts.free_zero) begin
              cmd.set_err = 1'b1; cmd.err_code = dtlpm_pkg::ST_POOL_FULL; state_next = S_FAIL;
            end else state_next = S_LAST;
          end
        end else if (sts.child_zero) begin
          cmd.set_err = 1'b1; cmd.err_code = dtlpm_pkg::ST_NOT_FOUND; state_next = S_LAST;
        end else begin
          cmd.take_child = 1'b1; state_next = S_HV_WAIT;
        end
      end
      S_HV_WAIT: state_next = S_HV_USE;
      S_HV_USE: begin
        cmd.mark_best = sts.hasv;
        state_next    = S_LAST;
      end
      S_LAST: begin
        if (!sts.last) state_next = S_IDLE;
        else if (sts.is_insert) state_next = sts.key_err ? S_RESP : S_INS_HV;
        else if (sts.best_zero) state_next = S_RESP;
        else begin
          cmd.goto_best = 1'b1; state_next = S_VAL_WAIT;
        end
      end
      S_INS_HV: begin
        cmd.write_val = 1'b1;
        if (sts.hasv) state_next = S_RESP;
        else begin
          cmd.set_hasv = 1'b1; state_next = S_INC;
        end
      end
      S_INC: begin
        if (sts.step_over) state_next = S_RESP;
        else begin
          cmd.inc_step = 1'b1;
          state_next   = sts.cursor_root ? S_RESP : S_INC_WAIT;
        end
      end
      S_INC_WAIT: state_next = S_INC;
      S_VAL_WAIT: state_next = S_VAL_USE;
      S_VAL_USE: begin
        cmd.capture_val = 1'b1;
        if (sts.is_remove) begin
          cmd.clear_hasv = 1'b1; state_next = S_DEC;
        end else state_next = S_RESP;
      end
      S_DEC: begin
        if (sts.step_over) state_next = S_RESP;
        else begin
          cmd.walk_step = 1'b1;
          cmd.walk_dec  = 1'b1;
          state_next    = sts.cursor_root ? S_RESP : S_DEC_WAIT;
        end
      end
      S_DEC_WAIT: state_next = S_DEC;
      S_FAIL: begin
        // undo the nodes this insert made, then park the cursor at the root
        if (sts.step_over) begin
          cmd.cursor_root = 1'b1; state_next = S_LAST;
        end else begin
          cmd.walk_step = 1'b1;
          state_next    = sts.cursor_root ? S_LAST : S_FAIL_WAIT;
        end
      end
      S_FAIL_WAIT: state_next = S_FAIL;
      S_RESP: begin
        if (sts.out_free) begin
          cmd.result = 1'b1; state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/dtlpm_dp.sv
`default_nettype none
module dtlpm_dp #(
  parameter int NODE_COUNT  = 1024,
  parameter int RADIX       = 10,
  parameter int MAX_KEY_LEN = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [1:0]             cmd,
  input  wire logic [7:0]             symbol,
  input  wire logic                   last_symbol,
  input  wire logic [VALUE_WIDTH-1:0] store_value,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [2:0]                  status,
  output logic [31:0]                 found_value,
  output logic [5:0]                  match_length,
  input  wire dtlpm_pkg::dtlpm_cmd_t  ctl,
  output dtlpm_pkg::dtlpm_sts_t       sts
);

  localparam int NW  = $clog2(NODE_COUNT);
  localparam int CW  = NW + 1;
  localparam int CIW = $clog2(NODE_COUNT * RADIX);
  localparam int KW  = dtlpm_pkg::KEY_W;
  localparam int DW  = dtlpm_pkg::DIGIT_W;
  localparam int SW  = dtlpm_pkg::STEP_W;

  logic [NW-1:0]          child_mem  [NODE_COUNT*RADIX];
  logic [NW-1:0]          parent_mem [NODE_COUNT];
  logic [DW-1:0]          slot_mem   [NODE_COUNT];
  logic                   hasv_mem   [NODE_COUNT];
  logic [VALUE_WIDTH-1:0] val_mem    [NODE_COUNT];
  logic [CW-1:0]          cnt_mem    [NODE_COUNT];
  logic [NW-1:0]          free_mem   [NODE_COUNT];

  logic [NW-1:0] child_rd, parent_rd, free_rd;
  logic [DW-1:0] slot_rd;
  logic          hasv_rd;
  logic [VALUE_WIDTH-1:0] val_rd;
  logic [CW-1:0] cnt_rd;

  logic [CIW-1:0] clear_idx;
  logic [NW-1:0]  cursor, best;
  logic [KW-1:0]  key_length, best_len;
  logic [2:0]     key_error;
  logic [1:0]     key_cmd;
  logic           in_key;
  logic [CW-1:0]  free_count;
  logic [SW-1:0]  steps;
  logic [7:0]     sym_q;
  logic           last_q;
  logic [VALUE_WIDTH-1:0] value_q, fval_q;

  logic [7:0]     sym_off;
  logic           good;
  logic [DW-1:0]  digit;
  logic [CIW-1:0] cur_addr, free_addr;
  logic           alloc_link, do_free, can_push, clear_low, is_ins;
  logic [NW-1:0]  clear_node;
  logic [CW-1:0]  new_cnt;

  logic           child_we, hasv_we, cnt_we, free_we, hasv_wd;
  logic [CIW-1:0] child_wa;
  logic [NW-1:0]  child_wd, node_wa, free_wa, free_wd;
  logic [CW-1:0]  cnt_wd;

  always_comb begin
    sym_off    = sym_q - dtlpm_pkg::DIGIT_BASE;
    good       = (sym_q >= dtlpm_pkg::DIGIT_BASE) && (sym_off < 8'(RADIX));
    digit      = sym_off[DW-1:0];
    cur_addr   = CIW'(cursor) * CIW'(RADIX) + CIW'(digit);
    free_addr  = CIW'(parent_rd) * CIW'(RADIX) + CIW'(slot_rd);
    alloc_link = ctl.alloc && (free_rd != '0);
    new_cnt    = (ctl.walk_dec && cnt_rd != '0) ? cnt_rd - 1'b1 : cnt_rd;
    do_free    = ctl.walk_step && (cursor != '0) && (new_cnt == '0);
    can_push   = free_count < CW'(NODE_COUNT);
    clear_low  = clear_idx < CIW'(NODE_COUNT);
    clear_node = clear_idx[NW-1:0];
    is_ins     = (key_cmd == dtlpm_pkg::CMD_INSERT);

    // freed nodes have empty child rows, so a new node needs no row clear
    child_we = ctl.clear_step || alloc_link || do_free;
    child_wa = ctl.clear_step ? clear_idx : (alloc_link ? cur_addr : free_addr);
    child_wd = alloc_link ? free_rd : '0;

    node_wa = ctl.clear_step ? clear_node : (alloc_link ? free_rd : cursor);
    hasv_we = (ctl.clear_step && clear_low) || alloc_link || ctl.set_hasv
              || ctl.clear_hasv || do_free;
    hasv_wd = ctl.set_hasv;
    cnt_we  = (ctl.clear_step && clear_low) || alloc_link || ctl.inc_step
              || ctl.walk_step;
    cnt_wd  = ctl.inc_step ? cnt_rd + 1'b1 : (ctl.walk_step ? new_cnt : '0);

    free_we = (ctl.clear_step && clear_low) || (do_free && can_push);
    free_wa = ctl.clear_step ? clear_node : free_count[NW-1:0];
    free_wd = ctl.clear_step ? NW'(NODE_COUNT - 1) - clear_node : cursor;
  end

  always_ff @(posedge clk) begin
    if (child_we) child_mem[child_wa] <= child_wd;
    child_rd <= child_mem[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (alloc_link) begin
      parent_mem[free_rd] <= cursor;
      slot_mem[free_rd]   <= digit;
    end
    parent_rd <= parent_mem[cursor];
    slot_rd   <= slot_mem[cursor];
  end

  always_ff @(posedge clk) begin
    if (hasv_we) hasv_mem[node_wa] <= hasv_wd;
    hasv_rd <= hasv_mem[cursor];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[node_wa] <= cnt_wd;
    cnt_rd <= cnt_mem[cursor];
  end

  always_ff @(posedge clk) begin
    if (ctl.write_val) val_mem[cursor] <= value_q;
    val_rd <= val_mem[cursor];
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_wa] <= free_wd;
    free_rd <= free_mem[free_count[NW-1:0] - 1'b1];
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      sym_q   <= symbol;
      last_q  <= last_symbol;
      value_q <= store_value;
    end
    if (ctl.capture_val) fval_q <= val_rd;
    if (ctl.result) begin
      status       <= is_ins ? key_error
                      : (best == '0 ? dtlpm_pkg::ST_NOT_FOUND : dtlpm_pkg::ST_OK);
      found_value  <= (is_ins || best == '0) ? 32'd0 : 32'(fval_q);
      match_length <= is_ins ? ((key_error != '0) ? 6'd0 : 6'(key_length))
                      : ((best == '0) ? 6'd0 : 6'(best_len));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_idx  <= '0;
      cursor     <= '0;
      best       <= '0;
      best_len   <= '0;
      key_length <= '0;
      key_error  <= '0;
      key_cmd    <= '0;
      in_key     <= 1'b0;
      free_count <= CW'(NODE_COUNT - 1);
      steps      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ctl.clear_step) clear_idx <= clear_idx + 1'b1;
      if (ctl.load_item && !in_key) begin
        in_key  <= 1'b1;
        key_cmd <= cmd;
      end
      if (ctl.set_err) key_error <= ctl.err_code;
      if (ctl.take_child || alloc_link) begin
        cursor     <= ctl.take_child ? child_rd : free_rd;
        key_length <= key_length + 1'b1;
      end
      if (ctl.alloc) free_count <= free_count - 1'b1;
      else if (do_free && can_push) free_count <= free_count + 1'b1;
      if (ctl.mark_best) begin
        best     <= cursor;
        best_len <= key_length;
      end
      if (ctl.goto_best) cursor <= best;
      if (ctl.cursor_root) cursor <= '0;
      if (ctl.inc_step || ctl.walk_step) begin
        steps <= steps + 1'b1;
        if (cursor != '0) cursor <= parent_rd;
      end
      if (out_valid && out_ready && !ctl.result) out_valid <= 1'b0;
      if (ctl.result) begin
        out_valid  <= 1'b1;
        cursor     <= '0;
        best       <= '0;
        best_len   <= '0;
        key_length <= '0;
        key_error  <= '0;
        key_cmd    <= '0;
        in_key     <= 1'b0;
        steps      <= '0;
      end
    end
  end

  always_comb begin
    sts.clear_last  = (clear_idx == CIW'(NODE_COUNT * RADIX - 1));
    sts.is_insert   = is_ins;
    sts.is_remove   = (key_cmd == dtlpm_pkg::CMD_REMOVE);
    sts.key_err     = (key_error != '0);
    sts.good        = good;
    sts.len_full    = (key_length >= KW'(MAX_KEY_LEN));
    sts.len_limit   = (key_length >= dtlpm_pkg::LOOKUP_LIMIT);
    sts.child_zero  = (child_rd == '0);
    sts.free_empty  = (free_count == '0);
    sts.free_zero   = (free_rd == '0);
    sts.hasv        = hasv_rd;
    sts.best_zero   = (best == '0);
    sts.cursor_root = (cursor == '0);
    sts.step_over   = (steps > SW'(MAX_KEY_LEN + 1));
    sts.last        = last_q;
    sts.out_free    = !out_valid || out_ready;
  end

  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    ctl.result |-> (!out_valid || out_ready)) else $error("result overwrites item");
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= CW'(NODE_COUNT - 1)) else $error("free count overflow");
  a_key_done: assert property (@(posedge clk) disable iff (rst)
    ctl.result |=> (cursor == '0 && !in_key && key_error == '0))
    else $error("key state not cleared");
  a_alloc_pop: assert property (@(posedge clk) disable iff (rst)
    ctl.alloc |-> (free_count != '0 && is_ins)) else $error("alloc from empty pool");

endmodule
`default_nettype wire

FILE: rtl/digit_trie_longest_prefix_match_unit.sv
`default_nettype none
// channel | handshake            | payload
// in      | in_valid / in_ready  | cmd, symbol, last_symbol, store_value
// out     | out_valid / out_ready| status, found_value, match_length
//
// Each digit passes through accept, decode, child-table read with allocation
// from the free list, and close. A lookup digit that finds a child adds a
// value-flag read; a digit after the key has failed skips the child-table
// read. At key end a remove, or an insert that sets a new value flag, walks
// up the parent links through the count and parent memories; a failing insert
// does the same walk. After reset a clearing pass over all NODE_COUNT*RADIX
// child entries (10240 by default) runs before in_ready rises. A result waits
// in the output register; the next key end stalls until it is taken.
module digit_trie_longest_prefix_match_unit #(
  parameter int NODE_COUNT  = 1024,
  parameter int RADIX       = 10,
  parameter int MAX_KEY_LEN = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             cmd,
  input  wire logic [7:0]             symbol,
  input  wire logic                   last_symbol,
  input  wire logic [VALUE_WIDTH-1:0] store_value,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [2:0]                  status,
  output logic [31:0]                 found_value,
  output logic [5:0]                  match_length
);

  dtlpm_pkg::dtlpm_cmd_t ctl;
  dtlpm_pkg::dtlpm_sts_t sts;

  dtlpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (ctl)
  );

  dtlpm_dp #(
    .NODE_COUNT  (NODE_COUNT),
    .RADIX       (RADIX),
    .MAX_KEY_LEN (MAX_KEY_LEN),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .symbol       (symbol),
    .last_symbol  (last_symbol),
    .store_value  (store_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found_value  (found_value),
    .match_length (match_length),
    .ctl          (ctl),
    .sts          (sts)
  );

endmodule
`default_nettype wire

FILE: verif/digit_trie_longest_prefix_match_unit_tb.sv
`default_nettype none
module digit_trie_longest_prefix_match_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES   = 1024;
  localparam int FANOUT  = 10;
  localparam int KEY_MAX = 32;
  localparam int STALL_LIMIT = 50000;

  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  sym;
    logic        last;
    logic [31:0] val;
  } key_item_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] value;
    logic [5:0]  length;
  } match_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = dtlpm_pkg::CMD_INSERT;
  logic [7:0]  symbol = '0;
  logic        last_symbol = 1'b0;
  logic [31:0] store_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [31:0] found_value;
  logic [5:0]  match_length;

  digit_trie_longest_prefix_match_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .symbol(symbol), .last_symbol(last_symbol), .store_value(store_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .found_value(found_value), .match_length(match_length)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow trie
  int unsigned child_tbl [NODES*FANOUT];
  int unsigned parent_of [NODES];
  int unsigned slot_of [NODES];
  bit          holds_val [NODES];
  logic [31:0] val_of [NODES];
  int unsigned path_cnt [NODES];
  int unsigned free_nodes [NODES];
  int unsigned free_cnt;
  int unsigned cursor, best, best_len, key_len, key_err, key_cmd;
  bit          in_key;

  key_item_t pending_items[$];
  match_t    expected_matches[$];
  string     stored_keys[$];
  int        errors = 0;
  bit        no_idle = 1'b0;
  bit        hold_req = 1'b0;

  function automatic void trie_reset();
    foreach (child_tbl[i]) child_tbl[i] = 0;
    for (int i = 0; i < NODES; i++) begin
      parent_of[i] = 0; slot_of[i] = 0; holds_val[i] = 0;
      val_of[i] = '0; path_cnt[i] = 0; free_nodes[i] = 0;
    end
    for (int i = 1; i < NODES; i++) free_nodes[i-1] = NODES - i;
    free_cnt = NODES - 1;
    cursor = 0; best = 0; best_len = 0; key_len = 0; key_err = 0;
    in_key = 0; key_cmd = 0;
  endfunction

  function automatic void release_node(int unsigned n);
    child_tbl[parent_of[n]*FANOUT + slot_of[n]] = 0;
    holds_val[n] = 0;
    path_cnt[n] = 0;
    if (free_cnt < NODES) begin
      free_nodes[free_cnt] = n;
      free_cnt++;
    end
  endfunction

  // climb to the root, dropping counts if asked and freeing empty nodes
  function automatic void prune_path(int unsigned n, bit dec);
    int unsigned steps, p;
    steps = 0;
    while (steps <= KEY_MAX + 1 && n < NODES) begin
      p = parent_of[n];
      if (dec && path_cnt[n] > 0) path_cnt[n]--;
      if (n == 0) break;
      if (path_cnt[n] == 0) release_node(n);
      n = p;
      steps++;
    end
  endfunction

  function automatic void abort_insert(int unsigned code);
    key_err = code;
    prune_path(cursor, 1'b0);
    cursor = 0;
  endfunction

  function automatic void predict_match(key_item_t it);
    int unsigned digit, c, n, steps;
    bit good;
    match_t m;
    m.status = dtlpm_pkg::ST_OK; m.value = '0; m.length = '0;
    digit = int'(it.sym) - int'(dtlpm_pkg::DIGIT_BASE);
    good = it.sym >= dtlpm_pkg::DIGIT_BASE && it.sym < dtlpm_pkg::DIGIT_BASE + FANOUT;
    if (!in_key) begin
      in_key = 1; key_cmd = it.cmd;
    end
    if (key_cmd == dtlpm_pkg::CMD_INSERT) begin
      if (key_err == 0) begin
        if (!good) abort_insert(dtlpm_pkg::ST_BAD_SYM);
        else if (key_len >= KEY_MAX) abort_insert(dtlpm_pkg::ST_TOO_LONG);
        else begin
          c = child_tbl[cursor*FANOUT + digit];
          if (c == 0) begin
            if (free_cnt == 0) abort_insert(dtlpm_pkg::ST_POOL_FULL);
            else begin
              free_cnt--;
              c = free_nodes[free_cnt];
              parent_of[c] = cursor; slot_of[c] = digit;
              holds_val[c] = 0; path_cnt[c] = 0;
              for (int k = 0; k < FANOUT; k++) child_tbl[c*FANOUT + k] = 0;
              child_tbl[cursor*FANOUT + digit] = c;
            end
          end
          if (key_err == 0) begin
            cursor = c; key_len++;
          end
        end
      end
      if (it.last) begin
        if (key_err != 0) m.status = 3'(key_err);
        else begin
          n = cursor;
          if (!holds_val[n]) begin
            holds_val[n] = 1;
            steps = 0;
            while (steps <= KEY_MAX + 1 && n < NODES) begin
              path_cnt[n]++;
              if (n == 0) break;
              n = parent_of[n];
              steps++;
            end
          end
          val_of[cursor] = it.val;
          m.length = 6'(key_len);
        end
      end
    end else begin
      if (key_err == 0) begin
        c = good ? child_tbl[cursor*FANOUT + digit] : 0;
        if (c == 0 || key_len >= dtlpm_pkg::LOOKUP_LIMIT) key_err = dtlpm_pkg::ST_NOT_FOUND;
        else begin
          cursor = c; key_len++;
          if (holds_val[c]) begin
            best = c; best_len = key_len;
          end
        end
      end
      if (it.last) begin
        if (best == 0) m.status = dtlpm_pkg::ST_NOT_FOUND;
        else begin
          m.value = val_of[best];
          m.length = 6'(best_len);
          if (key_cmd == dtlpm_pkg::CMD_REMOVE) begin
            holds_val[best] = 0;
            prune_path(best, 1'b1);
          end
        end
      end
    end
    if (it.last) begin
      expected_matches = {expected_matches, m};
      cursor = 0; best = 0; best_len = 0; key_len = 0; key_err = 0;
      in_key = 0; key_cmd = 0;
    end
  endfunction

  // input side
  bit in_took = 1'b0;
  int in_gap = 0;
  always @(posedge clk) begin
    in_took <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready)
      predict_match('{cmd: cmd, sym: symbol, last: last_symbol, val: store_value});
  end

  always @(negedge clk) begin
    key_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        it = pending_items.pop_front();
        cmd <= it.cmd; symbol <= it.sym; last_symbol <= it.last; store_value <= it.val;
        in_valid <= 1'b1;
        in_gap = no_idle ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side
  bit out_took = 1'b0;
  int out_gap = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    match_t m;
    out_took <= out_valid && out_ready && !rst;
    if (!rst && out_valid && out_ready) begin
      if (expected_matches.size() == 0) begin
        $error("unexpected result: status %0d value %0d length %0d",
               status, found_value, match_length);
        errors++;
      end else begin
        m = expected_matches.pop_front();
        if (status !== m.status) begin
          $error("status expected %0d got %0d", m.status, status);
          errors++;
        end
        if (found_value !== m.value) begin
          $error("found_value expected %0d got %0d", m.value, found_value);
          errors++;
        end
        if (match_length !== m.length) begin
          $error("match_length expected %0d got %0d", m.length, match_length);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (out_took) out_gap = no_idle ? 0 : $urandom_range(0, 3);
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("[digit_trie_longest_prefix_match_unit] ERROR");
      $finish;
    end
  end

  // queue one key; later items carry random cmd, non-final items random value
  task automatic queue_key(logic [1:0] c, string s, logic [31:0] v,
                           int bad_at = -1, logic [7:0] bad_sym = 8'd0);
    key_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.cmd  = (i == 0) ? c : 2'($urandom_range(0, 3));
      it.sym  = (i == bad_at) ? bad_sym : s[i];
      it.last = (i == s.len() - 1);
      it.val  = it.last ? v : $urandom;
      pending_items = {pending_items, it};
    end
  endtask

  function automatic string rand_digits(int len, int top);
    string s;
    s = "";
    for (int i = 0; i < len; i++) s = $sformatf("%s%0d", s, $urandom_range(0, top));
    return s;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_matches.size() > 0)
      @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  initial begin
    string s;
    int r, sent, idx, fills;
    trie_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed
    queue_key(dtlpm_pkg::CMD_INSERT, "1", 32'hFFFF_FFFF);
    queue_key(dtlpm_pkg::CMD_INSERT, "12", 32'h0);
    queue_key(dtlpm_pkg::CMD_LOOKUP, "123", 32'h0);
    queue_key(2'd3, "19", 32'h0);
    queue_key(dtlpm_pkg::CMD_INSERT, "12", 32'h5555_AAAA);
    queue_key(dtlpm_pkg::CMD_LOOKUP, "1", 32'h0, 0, 8'd0);
    queue_key(dtlpm_pkg::CMD_INSERT, "4567", 32'h1234, 2, 8'hFF);
    queue_key(dtlpm_pkg::CMD_LOOKUP, "4567", 32'h0);
    queue_key(dtlpm_pkg::CMD_INSERT, rand_digits(KEY_MAX + 1, 9), 32'h77);
    queue_key(dtlpm_pkg::CMD_INSERT, rand_digits(KEY_MAX, 9), 32'hAAAA_5555);
    queue_key(dtlpm_pkg::CMD_REMOVE, "1299", 32'h0);
    queue_key(dtlpm_pkg::CMD_REMOVE, "8", 32'h0);
    queue_key(dtlpm_pkg::CMD_LOOKUP, "12", 32'h0, 1, 8'h3A);
    queue_key(dtlpm_pkg::CMD_LOOKUP, "0", 32'h0, 0, 8'h2F);
    queue_key(dtlpm_pkg::CMD_REMOVE, "1", 32'h0);
    queue_key(dtlpm_pkg::CMD_LOOKUP, "1", 32'h0);
    drain();

    sent = 0;
    while (sent < 400) begin
      if (sent > 150 && sent < 250) no_idle = 1'b1;
      else no_idle = 1'b0;
      if (sent > 300 && sent < 320) hold_req = 1'b1;
      r = $urandom_range(0, 99);
      idx = (stored_keys.size() > 0) ? $urandom_range(0, stored_keys.size() - 1) : -1;
      if (r < 35 || idx < 0) begin
        s = rand_digits($urandom_range(1, 5), ($urandom_range(0, 3) == 0) ? 9 : 3);
        queue_key(dtlpm_pkg::CMD_INSERT, s, $urandom);
        stored_keys = {stored_keys, s};
      end else if (r < 60) begin
        s = stored_keys[idx];
        if ($urandom_range(0, 1)) s = {s, rand_digits($urandom_range(1, 3), 9)};
        queue_key(dtlpm_pkg::CMD_LOOKUP, s, $urandom);
      end else if (r < 78) begin
        s = ($urandom_range(0, 3) == 0) ? rand_digits($urandom_range(1, 4), 3)
                                         : stored_keys[idx];
        queue_key(dtlpm_pkg::CMD_REMOVE, s, $urandom);
        if (s == stored_keys[idx]) stored_keys.delete(idx);
      end else if (r < 85) begin
        queue_key(2'd3, rand_digits($urandom_range(1, 5), 3), $urandom);
      end else if (r < 93) begin
        s = rand_digits($urandom_range(1, 6), 3);
        queue_key(2'($urandom_range(0, 3)), s, $urandom,
                  $urandom_range(0, s.len() - 1), 8'($urandom_range(0, 255)));
      end else begin
        s = rand_digits($urandom_range(KEY_MAX - 1, KEY_MAX + 4), 1);
        queue_key(2'($urandom_range(0, 2)), s, $urandom);
      end
      sent += s.len();
      if (sent % 150 < 6 && sent > 100) drain();
      while (pending_items.size() > 40) @(negedge clk);
    end
    drain();
    no_idle = 1'b0;

    // fill the pool with long keys behind a long receiver stall, then overflow it
    hold_req = 1'b1;
    fills = 0;
    while (free_cnt >= 16 && fills < 45) begin
      queue_key(dtlpm_pkg::CMD_INSERT, rand_digits(KEY_MAX, 9), $urandom);
      fills++;
      while (pending_items.size() > 0) @(negedge clk);
    end
    for (int k = 0; k < 3; k++)
      queue_key(dtlpm_pkg::CMD_INSERT, rand_digits(KEY_MAX, 9), $urandom);
    drain();

    if (errors == 0) begin
      $display("[digit_trie_longest_prefix_match_unit] OK");
    end else begin
      $display("[digit_trie_longest_prefix_match_unit] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
